>>> hdl/fixed_bin_histogram_fill_macros.svh
// ----------------------------------------------------------------------------
// Histogram fill assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FIXED_BIN_HISTOGRAM_FILL_MACROS_SVH
`define FIXED_BIN_HISTOGRAM_FILL_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define FBH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram fill: assertion failed");

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define FBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram fill: assertion failed");

`else

`define FBH_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/fbh_pkg.sv
// ----------------------------------------------------------------------------
// Histogram fill package
// Widths, codes and payload types shared by the histogram fill modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbh_pkg;

  localparam int AXIS_BINS_MAX = 62;
  localparam int AXIS_CELLS    = AXIS_BINS_MAX + 2;
  localparam int STORE_DEPTH   = AXIS_CELLS * AXIS_CELLS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int COORD_W       = $clog2(AXIS_CELLS);
  localparam int COUNT_WIDTH   = 32;
  localparam int SAMPLE_W      = 32;
  localparam int BINS_W        = 6;
  localparam int BIN_IDX_W     = 8;
  localparam int REG_IDX_W     = 3;

  // Opcodes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TWO_DIM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BINS_X  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BINS_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LOW_Y   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_Y  = 3'd6;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [SAMPLE_W-1:0]  sample_x;
    logic signed [SAMPLE_W-1:0]  sample_y;
    logic signed [BIN_IDX_W-1:0] bin_x;
    logic signed [BIN_IDX_W-1:0] bin_y;
    logic [31:0]                 value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       cell_content;
    logic [ADDR_W-1:0] cell_index;
  } out_item_t;

  // Request to the axis binning unit
  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] low;
    logic signed [SAMPLE_W-1:0] high;
    logic [BINS_W-1:0]          nbins;
  } axis_req_t;

  // Result: coord is bin + 1 (0 underflow, nbins + 1 overflow)
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] coord;
  } axis_res_t;

endpackage

`default_nettype wire

>>> hdl/fbh_axis_bin.sv
// ----------------------------------------------------------------------------
// Histogram axis binning unit
// Maps one sample to a bin coordinate with a shared compare-subtract step.
// ----------------------------------------------------------------------------
`default_nettype none

module fbh_axis_bin import fbh_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire axis_req_t req,
  output axis_res_t      res
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + BINS_W + 1;
  localparam int MAG_W  = PROD_W - 1;
  localparam int TRY_W  = PROD_W;
  localparam int QUO_W  = COORD_W;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_SUB  = 3'd1;
  localparam logic [2:0] A_MUL  = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  logic [2:0]                a_st_r, a_st_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, low_r, high_r;
  logic [BINS_W-1:0]         n_r;
  logic signed [DIFF_W-1:0]  diff_r, den_r;
  logic [MAG_W-1:0]          rem_r;
  logic [DIFF_W-1:0]         dmag_r;
  logic                      neg_r, dzero_r, ovf_r;
  logic [QUO_W-1:0]          q_r;
  logic [2:0]                k_r;

  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         prod_mag;
  logic [TRY_W-1:0]          trial;
  logic                      fits;

  assign prod     = $signed({1'b0, n_r}) * diff_r;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  // shared compare-subtract: remainder minus shifted divisor
  assign trial    = {1'b0, rem_r} - (TRY_W'(dmag_r) << k_r);
  assign fits     = !trial[TRY_W-1];

  always_comb begin
    a_st_nxt = a_st_r;
    case (a_st_r)
      A_IDLE:  if (req.start) a_st_nxt = A_SUB;
      A_SUB:   a_st_nxt = A_MUL;
      A_MUL:   a_st_nxt = A_DIV;
      A_DIV:   if (k_r == 3'd0) a_st_nxt = A_FIN;
      // a new request may follow straight on from a finished one
      A_FIN:   a_st_nxt = req.start ? A_SUB : A_IDLE;
      default: a_st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_st_r <= A_IDLE;
    end else begin
      a_st_r <= a_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (a_st_r)
      A_IDLE, A_FIN: begin
        sample_r <= req.sample;
        low_r    <= req.low;
        high_r   <= req.high;
        n_r      <= req.nbins;
      end
      A_SUB: begin
        diff_r <= DIFF_W'(sample_r) - DIFF_W'(low_r);
        den_r  <= DIFF_W'(high_r) - DIFF_W'(low_r);
      end
      A_MUL: begin
        rem_r   <= prod_mag[MAG_W-1:0];
        dmag_r  <= den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
        neg_r   <= prod[PROD_W-1] ^ den_r[DIFF_W-1];
        dzero_r <= (den_r == '0);
        ovf_r   <= 1'b0;
        q_r     <= '0;
        k_r     <= 3'(QUO_W);
      end
      A_DIV: begin
        if (fits) begin
          rem_r <= trial[MAG_W-1:0];
          // top step only tells whether the quotient overflows the field
          if (k_r == 3'(QUO_W)) begin
            ovf_r <= 1'b1;
          end else begin
            q_r[k_r] <= 1'b1;
          end
        end
        k_r <= k_r - 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.done = (a_st_r == A_FIN);
    if (dzero_r) begin
      res.coord = n_r + COORD_W'(1);
    end else if (q_r == '0 && !ovf_r) begin
      res.coord = COORD_W'(1);
    end else if (neg_r) begin
      res.coord = '0;
    end else if (ovf_r || q_r >= n_r) begin
      res.coord = n_r + COORD_W'(1);
    end else begin
      res.coord = q_r + COORD_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/fbh_store.sv
// ----------------------------------------------------------------------------
// Histogram counter store
// Single write port, single registered read port counter memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fbh_store import fbh_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_W-1:0]      waddr,
  input  wire logic [COUNT_WIDTH-1:0] wdata,
  input  wire logic                   re,
  input  wire logic [ADDR_W-1:0]      raddr,
  output logic [COUNT_WIDTH-1:0]      rdata
);

  logic [COUNT_WIDTH-1:0] mem_r [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/fixed_bin_histogram_fill.sv
// ----------------------------------------------------------------------------
// Fixed-bin histogram fill
// One- or two-dimensional histogram of saturating counters with underflow
// and overflow cells, filled, set, read and cleared one item at a time.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A fill runs through the axis binning
// unit, which forms n*(sample-low) and then resolves the quotient by
// (high-low) in seven compare-subtract steps, one axis after the other,
// followed by a read-modify-write of the counter memory. Clear writes the
// 4096-entry memory one entry a cycle. After reset the same clearing pass
// runs before the first item is taken; configuration writes are accepted
// at any time. A finished result waits in an output register, so the next
// item can be taken before the result is transferred.
`default_nettype none

`include "fixed_bin_histogram_fill_macros.svh"

module fixed_bin_histogram_fill import fbh_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WX   = 3'd1;
  localparam logic [2:0] S_WY   = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration
  logic                       two_dim_r;
  logic [BINS_W-1:0]          bins_x_r, bins_y_r;
  logic signed [SAMPLE_W-1:0] low_x_r, high_x_r, low_y_r, high_y_r;

  logic [2:0]             state_r;
  in_item_t               item_r;
  logic [COORD_W-1:0]     cx_r, cy_r;
  logic [ADDR_W-1:0]      idx_r;
  logic [ADDR_W-1:0]      clr_addr_r;
  logic                   clr_report_r;
  logic [COUNT_WIDTH-1:0] result_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [BINS_W-1:0]      nx, ny;
  logic                   in_xfer;
  logic                   out_free;
  axis_req_t              axis_req;
  axis_res_t              axis_res;
  logic                   st_we;
  logic [ADDR_W-1:0]      st_waddr;
  logic [COUNT_WIDTH-1:0] st_wdata;
  logic [COUNT_WIDTH-1:0] st_rdata;
  logic [COUNT_WIDTH-1:0] upd_val;
  logic [ADDR_W-1:0]      idx_calc;

  function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] r);
    logic [BINS_W-1:0] n;
    n = r;
    if (r == '0) n = BINS_W'(1);
    if (r > BINS_W'(AXIS_BINS_MAX)) n = BINS_W'(AXIS_BINS_MAX);
    return n;
  endfunction

  // bin index to coordinate: below zero to underflow, at or above n to overflow
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [BIN_IDX_W-1:0] b,
                                                    input logic [BINS_W-1:0] n);
    logic [COORD_W-1:0] c;
    if (b < 0) begin
      c = '0;
    end else if (b[BIN_IDX_W-2:0] >= (BIN_IDX_W-1)'(n)) begin
      c = n + COORD_W'(1);
    end else begin
      c = b[COORD_W-1:0] + COORD_W'(1);
    end
    return c;
  endfunction

  assign nx        = eff_bins(bins_x_r);
  assign ny        = eff_bins(bins_y_r);
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one shared binning unit, x first, then y from the held item
  always_comb begin
    if (state_r == S_IDLE) begin
      axis_req.start  = in_xfer && (in_data.opcode == OP_FILL);
      axis_req.sample = in_data.sample_x;
      axis_req.low    = low_x_r;
      axis_req.high   = high_x_r;
      axis_req.nbins  = nx;
    end else begin
      axis_req.start  = (state_r == S_WX) && axis_res.done && two_dim_r;
      axis_req.sample = item_r.sample_y;
      axis_req.low    = low_y_r;
      axis_req.high   = high_y_r;
      axis_req.nbins  = ny;
    end
  end

  fbh_axis_bin u_axis (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (axis_req),
    .res   (axis_res)
  );

  always_comb begin
    case (item_r.opcode)
      OP_FILL: upd_val = (st_rdata == COUNT_MAX) ? st_rdata : st_rdata + COUNT_WIDTH'(1);
      OP_SET:  upd_val = COUNT_WIDTH'(item_r.value);
      default: upd_val = st_rdata;
    endcase
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_r;
    st_wdata = upd_val;
    if (state_r == S_CLR) begin
      st_we    = 1'b1;
      st_waddr = clr_addr_r;
      st_wdata = '0;
    end else if (state_r == S_UPD) begin
      st_we = (item_r.opcode == OP_FILL) || (item_r.opcode == OP_SET);
    end
  end

  fbh_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (state_r == S_RD),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  assign idx_calc = ADDR_W'(cx_r) + ADDR_W'(cy_r) * (ADDR_W'(nx) + ADDR_W'(2));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_dim_r <= 1'b0;
      bins_x_r  <= BINS_W'(62);
      low_x_r   <= '0;
      high_x_r  <= SAMPLE_W'(65536);
      bins_y_r  <= BINS_W'(62);
      low_y_r   <= '0;
      high_y_r  <= SAMPLE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TWO_DIM: two_dim_r <= cfg_data[0];
        REG_BINS_X:  bins_x_r  <= cfg_data[BINS_W-1:0];
        REG_LOW_X:   low_x_r   <= cfg_data;
        REG_HIGH_X:  high_x_r  <= cfg_data;
        REG_BINS_Y:  bins_y_r  <= cfg_data[BINS_W-1:0];
        REG_LOW_Y:   low_y_r   <= cfg_data;
        REG_HIGH_Y:  high_y_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_data.opcode)
              OP_CLEAR: begin
                clr_addr_r   <= '0;
                clr_report_r <= 1'b1;
                state_r      <= S_CLR;
              end
              OP_FILL: state_r <= S_WX;
              default: state_r <= S_ADDR;
            endcase
          end
        end
        S_WX: begin
          if (axis_res.done) begin
            state_r <= two_dim_r ? S_WY : S_ADDR;
          end
        end
        S_WY: begin
          if (axis_res.done) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: state_r <= S_RD;
        S_RD:   state_r <= S_UPD;
        S_UPD:  state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
            state_r <= clr_report_r ? S_FIN : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
      // set and get address straight from the bin indices
      cx_r   <= clamp_coord(in_data.bin_x, nx);
      cy_r   <= two_dim_r ? clamp_coord(in_data.bin_y, ny) : COORD_W'(0);
    end
    if (state_r == S_WX && axis_res.done) begin
      cx_r <= axis_res.coord;
      cy_r <= '0;
    end
    if (state_r == S_WY && axis_res.done) begin
      cy_r <= axis_res.coord;
    end
    if (state_r == S_ADDR) begin
      idx_r <= idx_calc;
    end
    if (state_r == S_UPD) begin
      result_r <= upd_val;
    end
    if (state_r == S_CLR) begin
      idx_r    <= '0;
      result_r <= '0;
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.cell_content <= 32'(result_r);
      out_data_r.cell_index   <= idx_r;
    end
  end

  `FBH_ASSERT_NEXT(a_one_item, clk, rst_n, in_xfer, !in_ready)
  `FBH_ASSERT_SAME(a_clr_blocks, clk, rst_n, state_r == S_CLR, !in_ready)
  `FBH_ASSERT_SAME(a_x_coord, clk, rst_n, (state_r == S_WX) && axis_res.done, axis_res.coord <= nx + BINS_W'(1))
  `FBH_ASSERT_SAME(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == S_FIN))

endmodule

`default_nettype wire

>>> sim/fixed_bin_histogram_fill_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram fill testbench
// Drives fill, set, get and clear items through the valid/ready ports under
// several axis settings and checks each result against a behavioral histogram
// kept in the bench, or against the expected cell given with a directed row.
// ----------------------------------------------------------------------------
module fixed_bin_histogram_fill_tb;
  import fbh_pkg::*;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 192;
  localparam int IDLE_LIMIT      = 20000;
  localparam int TAIL_CYCLES     = 64;

  typedef struct {
    bit                     is_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [31:0]            reg_word;
    in_item_t               item;
    bit                     typed;
    out_item_t              want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Behavioral copy of the histogram and its axis registers
  logic [COUNT_WIDTH-1:0] count_store [STORE_DEPTH];
  logic                   mode_2d = 1'b0;
  logic [BINS_W-1:0]      nbins_x = 6'd62;
  logic [BINS_W-1:0]      nbins_y = 6'd62;
  logic signed [31:0]     x_lo = 32'sd0;
  logic signed [31:0]     x_hi = 32'sd65536;
  logic signed [31:0]     y_lo = 32'sd0;
  logic signed [31:0]     y_hi = 32'sd65536;

  out_item_t pending_cells[$];
  row_t      directed_rows[$];
  out_item_t head;
  int        mismatches = 0;
  int        results_seen = 0;
  int        reg_writes = 0;
  int        ops_sent[4] = '{0, 0, 0, 0};
  int        idle_cycles = 0;
  int        stall_tick = 0;

  fixed_bin_histogram_fill i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint axis_count(input logic [BINS_W-1:0] r);
    longint n;
    n = longint'(r);
    if (n < 1) n = 1;
    if (n > AXIS_BINS_MAX) n = AXIS_BINS_MAX;
    return n;
  endfunction

  function automatic longint clamp_to_axis(input longint b, input longint n);
    if (b < 0) return -1;
    if (b >= n) return n;
    return b;
  endfunction

  function automatic longint sample_to_bin(input logic signed [31:0] s,
                                           input logic signed [31:0] lo,
                                           input logic signed [31:0] hi,
                                           input longint n);
    longint den;
    longint num;
    den = longint'(hi) - longint'(lo);
    num = n * (longint'(s) - longint'(lo));
    // empty range lands in overflow; quotient truncates toward zero
    if (den == 0) return n;
    return clamp_to_axis(num / den, n);
  endfunction

  // Apply one item to the behavioral histogram and return the cell it reports
  function automatic out_item_t histogram_op(input in_item_t it);
    out_item_t r;
    longint    nx;
    longint    ny;
    longint    bx;
    longint    by;
    longint    idx;
    r  = '0;
    nx = axis_count(nbins_x);
    ny = axis_count(nbins_y);
    by = -1;
    if (it.opcode == OP_CLEAR) begin
      foreach (count_store[i]) count_store[i] = '0;
      return r;
    end
    if (it.opcode == OP_FILL) begin
      bx = sample_to_bin(it.sample_x, x_lo, x_hi, nx);
      if (mode_2d) by = sample_to_bin(it.sample_y, y_lo, y_hi, ny);
    end else begin
      bx = clamp_to_axis(longint'($signed(it.bin_x)), nx);
      if (mode_2d) by = clamp_to_axis(longint'($signed(it.bin_y)), ny);
    end
    idx = (bx + 1) + (by + 1) * (nx + 2);
    if (idx < 0) idx = 0;
    if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
    case (it.opcode)
      OP_FILL: begin
        if (count_store[idx] != '1) count_store[idx] = count_store[idx] + 1'b1;
      end
      OP_SET: count_store[idx] = it.value[COUNT_WIDTH-1:0];
      default: ;
    endcase
    r.cell_content = count_store[idx];
    r.cell_index   = idx[ADDR_W-1:0];
    return r;
  endfunction

  // Mostly inside the range and near bin edges, sometimes anywhere
  function automatic logic [31:0] draw_sample(input logic signed [31:0] lo,
                                              input logic signed [31:0] hi,
                                              input longint n);
    longint      span;
    longint      s;
    int unsigned pick;
    span = longint'(hi) - longint'(lo);
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom();
    if (span == 0)
      s = longint'(lo) + longint'($urandom_range(0, 4)) - 2;
    else if (pick < 4)
      s = longint'(lo) + (span * longint'($urandom_range(0, int'(n)))) / n
          + longint'($urandom_range(0, 2)) - 1;
    else
      s = longint'(lo) + (span * (longint'($urandom_range(0, 1200)) - 100)) / 1000;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    longint      nx;
    longint      ny;
    nx = axis_count(nbins_x);
    ny = axis_count(nbins_y);
    it.sample_x = draw_sample(x_lo, x_hi, nx);
    it.sample_y = draw_sample(y_lo, y_hi, ny);
    if ($urandom_range(0, 9) < 6) it.bin_x = 8'($urandom_range(0, int'(nx) + 2)) - 8'd1;
    else it.bin_x = 8'($urandom());
    if ($urandom_range(0, 9) < 6) it.bin_y = 8'($urandom_range(0, int'(ny) + 2)) - 8'd1;
    else it.bin_y = 8'($urandom());
    // near-full values let later fills hit the saturation limit
    if ($urandom_range(0, 9) < 2) it.value = 32'hFFFF_FFFF - $urandom_range(0, 2);
    else it.value = $urandom();
    pick = $urandom_range(0, 999);
    if (pick < 6) it.opcode = OP_CLEAR;
    else if (pick < 640) it.opcode = OP_FILL;
    else if (pick < 820) it.opcode = OP_SET;
    else it.opcode = OP_GET;
    return it;
  endfunction

  function automatic void add_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] word);
    row_t r;
    r = '{default: '0};
    r.is_reg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_word = word;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_op(input logic [1:0] op, input logic [31:0] sx,
                                 input logic [31:0] sy, input logic [7:0] bx,
                                 input logic [7:0] by, input logic [31:0] val,
                                 input bit typed, input logic [31:0] content,
                                 input logic [ADDR_W-1:0] index);
    row_t r;
    r = '{default: '0};
    r.item.opcode      = op;
    r.item.sample_x    = sx;
    r.item.sample_y    = sy;
    r.item.bin_x       = bx;
    r.item.bin_y       = by;
    r.item.value       = val;
    r.typed            = typed;
    r.want.cell_content = content;
    r.want.cell_index  = index;
    directed_rows = {directed_rows, r};
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = histogram_op(it);
    if (typed) predicted = want;
    pending_cells = {pending_cells, predicted};
    ops_sent[it.opcode]++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TWO_DIM: mode_2d = word[0];
      REG_BINS_X:  nbins_x = word[BINS_W-1:0];
      REG_LOW_X:   x_lo    = word;
      REG_HIGH_X:  x_hi    = word;
      REG_BINS_Y:  nbins_y = word[BINS_W-1:0];
      REG_LOW_Y:   y_lo    = word;
      REG_HIGH_Y:  y_hi    = word;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold off the sender until every pending result has been transferred
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cells.size() != 0) @(negedge clk);
  endtask

  // Receiver stall pattern, chosen by bits 9:8 of the stall tick
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_cells.size() == 0) begin
        flag("result with nothing pending, cell_content", 32'd0, out_data.cell_content);
      end else begin
        head = pending_cells.pop_front();
        if (out_data.cell_content !== head.cell_content)
          flag("cell_content", head.cell_content, out_data.cell_content);
        if (out_data.cell_index !== head.cell_index)
          flag("cell_index", 32'(head.cell_index), 32'(out_data.cell_index));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("fixed_bin_histogram_fill: mismatch");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          k;
    int          a;
    int          burst_left;
    int          gap;
    logic [31:0] word;
    logic [31:0] lo;
    logic [31:0] hi;

    foreach (count_store[i]) count_store[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry: 1-D, 62 bins over 0..65536
    add_op(OP_GET,   32'd0, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'd0, 12'd1);
    add_op(OP_SET,   32'd0, 32'd0, 8'h80, 8'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 12'd0);
    // fill into a full underflow counter must hold it
    add_op(OP_FILL,  32'h8000_0000, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'hFFFF_FFFF, 12'd0);
    add_op(OP_SET,   32'd0, 32'd0, 8'h7F, 8'd0, 32'h8000_0000, 1, 32'h8000_0000, 12'd63);
    add_op(OP_FILL,  32'h7FFF_FFFF, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'h8000_0001, 12'd63);
    add_op(OP_FILL,  32'd0, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'd1, 12'd1);
    add_op(OP_FILL,  32'd65535, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'd1, 12'd62);
    add_op(OP_FILL,  32'd65536, 32'd0, 8'd0, 8'd0, 32'd0, 1, 32'h8000_0002, 12'd63);
    // just below low truncates into bin 0; y sample is ignored in 1-D
    add_op(OP_FILL,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 32'd0, 1, 32'd2, 12'd1);
    add_op(OP_GET,   32'd0, 32'h8000_0000, 8'd61, 8'h80, 32'hFFFF_FFFF, 1, 32'd1, 12'd62);
    add_op(OP_SET,   32'd0, 32'd0, 8'd5, 8'd0, 32'd12345, 1, 32'd12345, 12'd6);
    add_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
           1, 32'd0, 12'd0);
    add_op(OP_GET,   32'd0, 32'd0, 8'd5, 8'd0, 32'd0, 1, 32'd0, 12'd6);
    // 2-D, bins 0 acts as 1, bins 63 acts as 62, full x range, empty y range
    add_reg(REG_TWO_DIM, 32'd1);
    add_reg(REG_BINS_X,  32'd0);
    add_reg(REG_BINS_Y,  32'd63);
    add_reg(REG_LOW_X,   32'h8000_0000);
    add_reg(REG_HIGH_X,  32'h7FFF_FFFF);
    add_reg(REG_LOW_Y,   32'd100);
    add_reg(REG_HIGH_Y,  32'd100);
    add_op(OP_FILL,  32'd0, 32'd5, 8'd0, 8'd0, 32'd0, 1, 32'd1, 12'd190);
    add_op(OP_SET,   32'd0, 32'd0, 8'h7F, 8'hFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 12'd2);
    add_op(OP_GET,   32'd0, 32'd0, 8'hFF, 8'h7F, 32'd0, 1, 32'd0, 12'd189);
    add_op(OP_FILL,  32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0, 32'd0, 0, 32'd0, 12'd0);
    // reversed x range, small forward y range
    add_reg(REG_BINS_X,  32'd10);
    add_reg(REG_LOW_X,   32'd1000);
    add_reg(REG_HIGH_X,  32'd0);
    add_reg(REG_BINS_Y,  32'd4);
    add_reg(REG_LOW_Y,   32'd0);
    add_reg(REG_HIGH_Y,  32'd1000);
    add_op(OP_FILL,  32'd500, 32'd500, 8'd0, 8'd0, 32'd0, 0, 32'd0, 12'd0);
    add_op(OP_FILL,  32'd2000, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'd0, 0, 32'd0, 12'd0);
    add_op(OP_FILL,  32'hFFFF_EC78, 32'd1000, 8'd0, 8'd0, 32'd0, 0, 32'd0, 12'd0);
    // back to 1-D without clearing: cells are read under the new layout
    add_reg(REG_TWO_DIM, 32'd0);
    add_reg(REG_BINS_X,  32'd62);
    add_op(OP_GET,   32'd0, 32'd0, 8'd41, 8'd0, 32'd0, 0, 32'd0, 12'd0);
    add_op(OP_GET,   32'd0, 32'd0, 8'd1, 8'd0, 32'd0, 0, 32'd0, 12'd0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_reg) begin
        wait_drain();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_word);
      end else begin
        if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 4));
        push_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drain();
      // first two settings are the extremes: widest and fully reversed ranges
      word    = $urandom();
      word[0] = (ph == 0) || ($urandom_range(0, 1) == 1);
      write_reg(REG_TWO_DIM, word);
      word = (ph == 0) ? 32'd63 : (ph == 1) ? 32'd0 : $urandom();
      write_reg(REG_BINS_X, word);
      word = (ph == 0) ? 32'd0 : (ph == 1) ? 32'd62 : $urandom();
      write_reg(REG_BINS_Y, word);
      for (a = 0; a < 2; a++) begin
        if (ph == 0) begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
        end else if (ph == 1) begin
          lo = 32'h7FFF_FFFF;
          hi = 32'h8000_0000;
        end else begin
          case ($urandom_range(0, 4))
            0: begin
              lo = $urandom_range(0, 20000) - 32'd10000;
              hi = lo + $urandom_range(1, 4000);
            end
            1: begin
              hi = $urandom_range(0, 20000) - 32'd10000;
              lo = hi + $urandom_range(1, 4000);
            end
            2: begin
              lo = $urandom();
              hi = lo;
            end
            3: begin
              lo = $urandom();
              hi = $urandom();
            end
            default: begin
              lo = $urandom();
              hi = lo + $urandom_range(1, 1 << 20);
            end
          endcase
        end
        write_reg((a == 0) ? REG_LOW_X : REG_LOW_Y, lo);
        write_reg((a == 0) ? REG_HIGH_X : REG_HIGH_Y, hi);
      end

      burst_left = 0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && ph % 2 == 1) wait_drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // every fourth setting skips the random sender gaps between bursts
          if (ph % 4 != 3) begin
            gap = $urandom_range(0, 7);
            if (gap != 0) idle_for(gap);
          end
        end
        burst_left--;
        push_item(random_item(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_cells.size() != 0)
      flag("results never delivered", 32'd0, 32'(pending_cells.size()));

    $display("Sent %0d fills, %0d sets, %0d gets, %0d clears over %0d register writes",
             ops_sent[OP_FILL], ops_sent[OP_SET], ops_sent[OP_GET], ops_sent[OP_CLEAR],
             reg_writes);
    $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("fixed_bin_histogram_fill: match");
    else
      $display("fixed_bin_histogram_fill: mismatch");
    $finish;
  end

endmodule

>>> fixed_bin_histogram_fill.f
+incdir+hdl
hdl/fbh_pkg.sv
hdl/fbh_axis_bin.sv
hdl/fbh_store.sv
hdl/fixed_bin_histogram_fill.sv
sim/fixed_bin_histogram_fill_tb.sv
